>>> rtl/core/pps_pkg.sv
// Types, constants and helpers shared by the priority process scheduler.
`default_nettype none

package pps_pkg;

	localparam int SLOTS = 16;
	localparam int PRIORITY_BITS = 8;

	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int PRIO_W = PRIORITY_BITS;
	localparam int LIVE_W = 5;

	typedef enum logic [1:0] {
		OP_CREATE = 2'd0,
		OP_EXIT = 2'd1,
		OP_SLEEP = 2'd2,
		OP_SCHEDULE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK = 2'd0,
		STATUS_FULL = 2'd1,
		STATUS_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		SLOT_UNUSED = 3'd0,
		SLOT_READY = 3'd1,
		SLOT_RUNNING = 3'd2,
		SLOT_SLEEPING = 3'd3,
		SLOT_ZOMBIE = 3'd4
	} slot_state_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_PICK = 3'b100
	} fsm_t;

	typedef struct packed {
		op_t opcode;
		logic [7:0] priority_req;
		logic [31:0] parent_pid;
		logic [31:0] initial_context;
		logic [31:0] target_pid;
		logic [31:0] delay_ticks;
		logic [31:0] now_tick;
		logic [31:0] saved_context;
	} req_t;

	typedef struct packed {
		status_t status;
		logic [31:0] new_pid;
		logic [31:0] next_context;
		logic [31:0] running_pid;
		logic [LIVE_W-1:0] live_count;
	} rsp_t;

	typedef struct packed {
		slot_state_t state;
		logic [31:0] pid;
		logic [31:0] parent;
		logic [PRIO_W-1:0] prio;
		logic [31:0] wake;
		logic [31:0] ctx;
	} slot_rec_t;

	localparam int REC_W = $bits(slot_rec_t);

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] a);
		logic [SLOT_W-1:0] n;
		if (a == SLOT_W'(SLOTS - 1)) begin
			n = '0;
		end else begin
			n = a + SLOT_W'(1);
		end
		return n;
	endfunction

	function automatic slot_rec_t reset_rec(input logic [SLOT_W-1:0] idx);
		slot_rec_t r;
		r = '0;
		r.state = (idx == '0) ? SLOT_READY : SLOT_UNUSED;
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/pps_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/priority_process_scheduler.sv
// Priority process scheduler: slot table in RAM, scanned one slot per cycle.
`default_nettype none

// An item is taken when start is high and busy is low; its result appears on rsp for
// exactly one cycle with done high and cannot be held off. All slot records live in one
// RAM with one read and one write port, so create, exit and schedule walk the table
// one slot per cycle through the registered read port; sleep reads only the running
// slot, or no slot for zero ticks. A bit per slot marks entries written since reset,
// so no clearing pass runs after reset.
module priority_process_scheduler import pps_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	fsm_t st_q;
	req_t req_q;
	rsp_t rsp_q;
	logic done_q;

	logic [SLOT_W-1:0] cur_q;
	logic [SLOT_W-1:0] issue_addr_q;
	logic [CNT_W-1:0] issue_left_q;
	logic [CNT_W-1:0] live_q;
	logic [SLOT_W-1:0] best_q;
	logic [PRIO_W-1:0] best_pri_q;
	logic have_q;
	logic found_q;
	logic [31:0] pid_ctr_q;
	logic [31:0] cur_pid_q;
	logic [31:0] new_pid_q;
	logic [SLOTS-1:0] valid_q;

	logic v_s1;
	logic vb_s1;
	logic [SLOT_W-1:0] idx_s1;

	logic accept;
	logic scan_issue;
	logic scan_end;
	logic proc;
	logic hit;
	logic sched_take;
	logic live_inc;
	logic live_dec;
	logic [CNT_W-1:0] live_next;

	logic re;
	logic we;
	logic [SLOT_W-1:0] raddr;
	logic [REC_W-1:0] rdata;
	slot_rec_t rec;
	slot_rec_t wrec;

	pps_ram #(
		.WIDTH(REC_W),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk(clk),
		.we(we),
		.waddr(idx_s1),
		.wdata(wrec),
		.re(re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign accept = start && (st_q == ST_IDLE);
	assign busy = (st_q != ST_IDLE);
	assign done = done_q;
	assign rsp = rsp_q;

	assign scan_issue = (st_q == ST_SCAN) && (issue_left_q != '0);
	assign scan_end = (st_q == ST_SCAN) && (issue_left_q == '0) && !v_s1;
	assign proc = (st_q == ST_SCAN) && v_s1 && !found_q;

	assign re = scan_issue || (scan_end && (req_q.opcode == OP_SCHEDULE));
	assign raddr = scan_issue ? issue_addr_q : (have_q ? best_q : '0);
	assign rec = vb_s1 ? slot_rec_t'(rdata) : reset_rec(idx_s1);

	always_comb begin
		we = 1'b0;
		hit = 1'b0;
		live_inc = 1'b0;
		live_dec = 1'b0;
		sched_take = 1'b0;
		wrec = rec;
		if (st_q == ST_PICK) begin
			we = 1'b1;
			wrec.state = SLOT_RUNNING;
			live_inc = (rec.state == SLOT_UNUSED) || (rec.state == SLOT_ZOMBIE);
		end else if (proc) begin
			case (req_q.opcode)
				OP_CREATE: begin
					if (rec.state == SLOT_UNUSED) begin
						hit = 1'b1;
						we = 1'b1;
						live_inc = 1'b1;
						wrec.state = SLOT_READY;
						wrec.pid = pid_ctr_q;
						wrec.parent = req_q.parent_pid;
						wrec.prio = PRIO_W'(req_q.priority_req);
						wrec.wake = '0;
						wrec.ctx = req_q.initial_context;
					end
				end
				OP_EXIT: begin
					if (rec.state != SLOT_UNUSED && rec.pid == req_q.target_pid) begin
						hit = 1'b1;
						we = 1'b1;
						live_dec = (rec.state != SLOT_ZOMBIE);
						wrec.state = SLOT_ZOMBIE;
					end
				end
				OP_SLEEP: begin
					we = 1'b1;
					live_inc = (rec.state == SLOT_UNUSED) || (rec.state == SLOT_ZOMBIE);
					wrec.state = SLOT_SLEEPING;
					wrec.wake = req_q.now_tick + req_q.delay_ticks;
				end
				OP_SCHEDULE: begin
					we = 1'b1;
					if (idx_s1 == cur_q) begin
						wrec.ctx = req_q.saved_context;
						if (wrec.state == SLOT_RUNNING) begin
							wrec.state = SLOT_READY;
						end
					end
					if (wrec.state == SLOT_SLEEPING && req_q.now_tick >= wrec.wake) begin
						wrec.state = SLOT_READY;
					end
					if (wrec.state == SLOT_ZOMBIE) begin
						wrec.state = SLOT_UNUSED;
					end
					sched_take = (wrec.state == SLOT_READY) && (wrec.prio >= best_pri_q);
				end
				default: begin
					we = 1'b0;
				end
			endcase
		end
	end

	assign live_next = live_q + CNT_W'(live_inc) - CNT_W'(live_dec);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			done_q <= 1'b0;
			cur_q <= '0;
			issue_addr_q <= '0;
			issue_left_q <= '0;
			live_q <= CNT_W'(1);
			best_q <= '0;
			best_pri_q <= '0;
			have_q <= 1'b0;
			found_q <= 1'b0;
			pid_ctr_q <= 32'd1;
			cur_pid_q <= '0;
			new_pid_q <= '0;
			valid_q <= '0;
			v_s1 <= 1'b0;
		end else begin
			done_q <= (st_q == ST_PICK) || (scan_end && (req_q.opcode != OP_SCHEDULE));
			v_s1 <= scan_issue;
			if (we) begin
				valid_q[idx_s1] <= 1'b1;
			end
			live_q <= live_next;
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						st_q <= ST_SCAN;
						found_q <= 1'b0;
						have_q <= 1'b0;
						best_q <= '0;
						best_pri_q <= '0;
						new_pid_q <= '0;
						case (req.opcode)
							OP_CREATE: begin
								issue_addr_q <= SLOT_W'(1);
								issue_left_q <= CNT_W'(SLOTS - 1);
							end
							OP_EXIT: begin
								issue_addr_q <= '0;
								issue_left_q <= CNT_W'(SLOTS);
							end
							OP_SLEEP: begin
								issue_addr_q <= cur_q;
								issue_left_q <= CNT_W'(req.delay_ticks != '0);
							end
							default: begin
								issue_addr_q <= next_slot(cur_q);
								issue_left_q <= CNT_W'(SLOTS);
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_issue) begin
						issue_addr_q <= next_slot(issue_addr_q);
					end
					if (hit) begin
						found_q <= 1'b1;
						issue_left_q <= '0;
					end else if (scan_issue) begin
						issue_left_q <= issue_left_q - CNT_W'(1);
					end
					if (hit && req_q.opcode == OP_CREATE) begin
						pid_ctr_q <= pid_ctr_q + 32'd1;
						new_pid_q <= pid_ctr_q;
						if (idx_s1 == cur_q) begin
							cur_pid_q <= pid_ctr_q;
						end
					end
					if (sched_take) begin
						best_q <= idx_s1;
						best_pri_q <= wrec.prio;
						have_q <= 1'b1;
					end
					if (scan_end) begin
						if (req_q.opcode == OP_SCHEDULE) begin
							st_q <= ST_PICK;
						end else begin
							st_q <= ST_IDLE;
						end
					end
				end
				ST_PICK: begin
					cur_q <= idx_s1;
					cur_pid_q <= rec.pid;
					st_q <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (re) begin
			idx_s1 <= raddr;
			vb_s1 <= valid_q[raddr];
		end
		if (scan_end && req_q.opcode != OP_SCHEDULE) begin
			if (!found_q && req_q.opcode == OP_CREATE) begin
				rsp_q.status <= STATUS_FULL;
			end else if (!found_q && req_q.opcode == OP_EXIT) begin
				rsp_q.status <= STATUS_NOT_FOUND;
			end else begin
				rsp_q.status <= STATUS_OK;
			end
			rsp_q.new_pid <= new_pid_q;
			rsp_q.next_context <= '0;
			rsp_q.running_pid <= cur_pid_q;
			rsp_q.live_count <= LIVE_W'(live_q);
		end
		if (st_q == ST_PICK) begin
			rsp_q.status <= STATUS_OK;
			rsp_q.new_pid <= '0;
			rsp_q.next_context <= rec.ctx;
			rsp_q.running_pid <= rec.pid;
			rsp_q.live_count <= LIVE_W'(live_next);
		end
	end

endmodule

`default_nettype wire

>>> tb/pps_tb_pkg.sv
// Scoreboard for the priority process scheduler testbench: slot table predictor and check.
package pps_tb_pkg;
	import pps_pkg::*;

	class sched_scoreboard;
		slot_state_t proc_state[SLOTS];
		logic [31:0] proc_id[SLOTS];
		logic [31:0] proc_parent[SLOTS];
		logic [PRIO_W-1:0] proc_prio[SLOTS];
		logic [31:0] proc_wake[SLOTS];
		logic [31:0] proc_ctx[SLOTS];
		int unsigned running_slot;
		logic [31:0] pid_seq;
		rsp_t expected_rsp[$];
		int unsigned errors;
		int unsigned results_checked;
		int unsigned op_count[4];
		int unsigned full_count;
		int unsigned missing_count;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				proc_state[i] = (i == 0) ? SLOT_READY : SLOT_UNUSED;
				proc_id[i] = '0;
				proc_parent[i] = '0;
				proc_prio[i] = '0;
				proc_wake[i] = '0;
				proc_ctx[i] = '0;
			end
			running_slot = 0;
			pid_seq = 32'd1;
			errors = 0;
			results_checked = 0;
			op_count = '{default: 0};
			full_count = 0;
			missing_count = 0;
		endfunction

		function rsp_t apply_command(req_t r);
			rsp_t o;
			bit found;
			int unsigned best;
			int unsigned s;
			int unsigned live;
			logic [PRIO_W-1:0] best_prio;
			o = '0;
			o.status = STATUS_OK;
			found = 1'b0;
			case (r.opcode)
				OP_CREATE: begin
					for (int i = 1; i < SLOTS && !found; i++) begin
						if (proc_state[i] == SLOT_UNUSED) begin
							found = 1'b1;
							proc_id[i] = pid_seq;
							o.new_pid = pid_seq;
							pid_seq = pid_seq + 32'd1;
							proc_parent[i] = r.parent_pid;
							proc_prio[i] = PRIO_W'(r.priority_req);
							proc_state[i] = SLOT_READY;
							proc_wake[i] = '0;
							proc_ctx[i] = r.initial_context;
						end
					end
					if (!found) begin
						o.status = STATUS_FULL;
					end
				end
				OP_EXIT: begin
					for (int i = 0; i < SLOTS && !found; i++) begin
						if (proc_state[i] != SLOT_UNUSED && proc_id[i] == r.target_pid) begin
							proc_state[i] = SLOT_ZOMBIE;
							found = 1'b1;
						end
					end
					if (!found) begin
						o.status = STATUS_NOT_FOUND;
					end
				end
				OP_SLEEP: begin
					if (r.delay_ticks != '0) begin
						proc_wake[running_slot] = r.now_tick + r.delay_ticks;
						proc_state[running_slot] = SLOT_SLEEPING;
					end
				end
				default: begin
					proc_ctx[running_slot] = r.saved_context;
					if (proc_state[running_slot] == SLOT_RUNNING) begin
						proc_state[running_slot] = SLOT_READY;
					end
					for (int i = 0; i < SLOTS; i++) begin
						if (proc_state[i] == SLOT_SLEEPING &&
								r.now_tick >= proc_wake[i]) begin
							proc_state[i] = SLOT_READY;
						end
						if (proc_state[i] == SLOT_ZOMBIE) begin
							proc_state[i] = SLOT_UNUSED;
						end
					end
					best = 0;
					best_prio = '0;
					for (int k = 1; k <= SLOTS; k++) begin
						s = (running_slot + k) % SLOTS;
						if (proc_state[s] == SLOT_READY && proc_prio[s] >= best_prio) begin
							best_prio = proc_prio[s];
							best = s;
							found = 1'b1;
						end
					end
					running_slot = found ? best : 0;
					proc_state[running_slot] = SLOT_RUNNING;
					o.next_context = proc_ctx[running_slot];
				end
			endcase
			live = 0;
			for (int i = 0; i < SLOTS; i++) begin
				if (proc_state[i] != SLOT_UNUSED && proc_state[i] != SLOT_ZOMBIE) begin
					live++;
				end
			end
			o.running_pid = proc_id[running_slot];
			o.live_count = LIVE_W'(live);
			return o;
		endfunction

		function void note_request(req_t r);
			rsp_t o;
			o = apply_command(r);
			op_count[int'(r.opcode)]++;
			if (o.status == STATUS_FULL) begin
				full_count++;
			end
			if (o.status == STATUS_NOT_FOUND) begin
				missing_count++;
			end
			expected_rsp.push_back(o);
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (expected_rsp.size() == 0) begin
				$error("result with no item outstanding: %p", got);
				errors++;
				return;
			end
			want = expected_rsp.pop_front();
			results_checked++;
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.new_pid !== want.new_pid) begin
				$error("new_pid: expected %0h, got %0h", want.new_pid, got.new_pid);
				errors++;
			end
			if (got.next_context !== want.next_context) begin
				$error("next_context: expected %0h, got %0h",
					want.next_context, got.next_context);
				errors++;
			end
			if (got.running_pid !== want.running_pid) begin
				$error("running_pid: expected %0h, got %0h",
					want.running_pid, got.running_pid);
				errors++;
			end
			if (got.live_count !== want.live_count) begin
				$error("live_count: expected %0d, got %0d", want.live_count, got.live_count);
				errors++;
			end
		endfunction
	endclass

endpackage

>>> tb/priority_process_scheduler_tb.sv
// Testbench top for the priority process scheduler: directed and random commands under idle phases.
module priority_process_scheduler_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pps_pkg::*;
	import pps_tb_pkg::*;

	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned PHASE_ITEMS = 200;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	rsp_t rsp;
	int unsigned stall_cycles = 0;
	int unsigned items_sent = 0;
	logic [31:0] tick_now = '0;
	int unsigned idle_plan[4] = '{0, 57, 0, 20};
	sched_scoreboard sb = new();

	priority_process_scheduler DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.rsp(rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_response(rsp);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$error("no item accepted and no result for %0d cycles", STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic req_t make_req(op_t op, logic [7:0] prio, logic [31:0] parent,
			logic [31:0] ictx, logic [31:0] target, logic [31:0] ticks, logic [31:0] now,
			logic [31:0] sctx);
		req_t r;
		r.opcode = op;
		r.priority_req = prio;
		r.parent_pid = parent;
		r.initial_context = ictx;
		r.target_pid = target;
		r.delay_ticks = ticks;
		r.now_tick = now;
		r.saved_context = sctx;
		return r;
	endfunction

	function automatic req_t random_request();
		req_t r;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 25) begin
			r.opcode = OP_CREATE;
		end else if (pick < 50) begin
			r.opcode = OP_EXIT;
		end else if (pick < 65) begin
			r.opcode = OP_SLEEP;
		end else begin
			r.opcode = OP_SCHEDULE;
		end
		r.priority_req = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom);
		r.parent_pid = $urandom;
		r.initial_context = $urandom;
		r.saved_context = $urandom;
		if ($urandom_range(99) < 80) begin
			r.target_pid = sb.proc_id[$urandom_range(SLOTS - 1)];
		end else begin
			r.target_pid = $urandom;
		end
		pick = $urandom_range(99);
		if (pick < 10) begin
			r.delay_ticks = '0;
		end else if (pick < 20) begin
			r.delay_ticks = $urandom;
		end else begin
			r.delay_ticks = $urandom_range(40, 1);
		end
		if ($urandom_range(99) < 3) begin
			tick_now = $urandom;
		end else begin
			tick_now = tick_now + $urandom_range(6);
		end
		r.now_tick = tick_now;
		return r;
	endfunction

	task automatic send_item(input req_t item, input int unsigned idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		req <= item;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		sb.note_request(item);
		items_sent++;
		@(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_item(make_req(OP_SCHEDULE, '0, '0, '0, '0, '0, '0, '1), 0);
		for (int i = 1; i < SLOTS; i++) begin
			send_item(make_req(OP_CREATE, (i == 1) ? 8'hFF : (i == 2) ? 8'h00 : 8'(i % 4),
				(i % 2) ? '1 : '0, (i % 2) ? 32'(i) : '1, '0, '0, '0, '0), 0);
		end
		send_item(make_req(OP_CREATE, 8'h10, '1, '1, '0, '0, '0, '0), 0);
		send_item(make_req(OP_EXIT, '0, '0, '0, '1, '0, '0, '0), 0);
		send_item(make_req(OP_SLEEP, '0, '0, '0, '0, '0, 32'd3, '0), 0);
		send_item(make_req(OP_SCHEDULE, '0, '0, '0, '0, '0, 32'd5, '0), 0);
		send_item(make_req(OP_SLEEP, '0, '0, '0, '0, '1, 32'd10, '0), 0);
		send_item(make_req(OP_EXIT, '0, '0, '0, 32'd2, '0, '0, '0), 0);
		send_item(make_req(OP_SCHEDULE, '0, '0, '0, '0, '0, '1, '1), 0);
		send_item(make_req(OP_EXIT, '0, '0, '0, '0, '0, '0, '0), 0);
		send_item(make_req(OP_SCHEDULE, '0, '0, '0, '0, '0, '0, 32'h5A5A_A5A5), 0);

		foreach (idle_plan[p]) begin
			repeat (PHASE_ITEMS) begin
				send_item(random_request(), idle_plan[p]);
			end
		end
		start <= 1'b0;

		while (sb.expected_rsp.size() != 0) begin
			@(posedge clk);
		end
		repeat (25) @(posedge clk);

		$display("Ran %0d items, %0d results checked, with sender idle phases of 0, 57 and 20%%.",
			items_sent, sb.results_checked);
		$display("Creates %0d (%0d on a full table), exits %0d (%0d unknown pid),",
			sb.op_count[OP_CREATE], sb.full_count, sb.op_count[OP_EXIT], sb.missing_count);
		$display("sleeps %0d, schedules %0d.",
			sb.op_count[OP_SLEEP], sb.op_count[OP_SCHEDULE]);
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/core/pps_pkg.sv
rtl/core/pps_ram.sv
rtl/core/priority_process_scheduler.sv
tb/pps_tb_pkg.sv
tb/priority_process_scheduler_tb.sv
